>>> sv/sfla_pkg.sv
// Shared types, codes and constants of the slab free-list allocator.
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

   localparam int unsigned ADDR_W    = 32;
   localparam int unsigned SIZE_W    = 13;
   localparam int unsigned COUNT_W   = 13;
   localparam int unsigned STRIDE_W  = 14;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned CSR_IDX_W = 2;

   localparam int unsigned DEF_PAGE_BYTES    = 4096;
   localparam int unsigned DEF_WINDOW_PAGES  = 8;
   localparam int unsigned DEF_GRANULE_BYTES = 8;
   localparam int unsigned DEF_CLASS_COUNT   = 3;

   typedef enum logic [KIND_W-1:0] {
      KIND_DONATE = 2'd0,
      KIND_ALLOC  = 2'd1,
      KIND_FREE   = 2'd2,
      KIND_QUERY  = 2'd3
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SMALL_BYTES  = 2'd0,
      CSR_MEDIUM_BYTES = 2'd1,
      CSR_LARGE_BYTES  = 2'd2,
      CSR_WINDOW_BASE  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SIZE_W-1:0] size;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  granted_address;
      logic               success;
      logic [COUNT_W-1:0] free_objects;
      logic [COUNT_W-1:0] live_objects;
   } rsp_type;

   function automatic logic [SIZE_W-1:0] reset_size(input int unsigned c);
      logic [SIZE_W-1:0] s;
      unique case (c)
         0:       s = SIZE_W'(32);
         1:       s = SIZE_W'(128);
         2:       s = SIZE_W'(512);
         default: s = '0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

>>> sv/sfla_rem.sv
// Bit-serial remainder unit: dividend modulo stride, one dividend bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module sfla_rem
   import sfla_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [ADDR_W-1:0]   dividend,
   input  wire logic [STRIDE_W-1:0] divisor,
   output logic                     done,
   output logic                     zero
);

   localparam int unsigned CNT_W = $clog2(ADDR_W) + 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ADDR_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [ADDR_W-1:0]   dvd_ff, dvd_in;
   logic [STRIDE_W-1:0] div_ff, div_in;
   logic [STRIDE_W-1:0] rem_ff, rem_in;

   always_comb begin
      logic [STRIDE_W:0] t;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      t       = {rem_ff, dvd_ff[ADDR_W-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (t >= {1'b0, div_ff}) begin
            t = t - {1'b0, div_ff};
         end
         rem_in = t[STRIDE_W-1:0];
         dvd_in = {dvd_ff[ADDR_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign zero = (rem_ff == '0);

endmodule

`default_nettype wire

>>> sv/slab_free_list_allocator_top.sv
// Slab allocator top level: size-class free lists kept in one slot-link memory.
// Each request yields one response. Allocate reads the list head, then does a
// link read-modify-write of the slot memory; an allocate that fails reads
// nothing. Donate, when the page is carved, pushes PAGE_BYTES / stride slots,
// one memory write each. Free checks the classes in turn, runs the bit-serial
// stride check for every class whose range holds the address, then looks up
// the slot; a null address is refused without a lookup. After reset the slot
// memory is swept once over all WINDOW_PAGES * PAGE_BYTES / GRANULE_BYTES
// slots (4096 by default) to clear the free marks, during which no request is
// taken; register writes are taken always.
`timescale 1ns / 1ps
`default_nettype none

module slab_free_list_allocator_top
   import sfla_pkg::*;
#(
   parameter int unsigned PAGE_BYTES    = DEF_PAGE_BYTES,
   parameter int unsigned WINDOW_PAGES  = DEF_WINDOW_PAGES,
   parameter int unsigned GRANULE_BYTES = DEF_GRANULE_BYTES,
   parameter int unsigned CLASS_COUNT   = DEF_CLASS_COUNT
)(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [ADDR_W-1:0]    csr_data
);

   localparam int unsigned GS           = $clog2(GRANULE_BYTES);
   localparam int unsigned PS           = $clog2(PAGE_BYTES);
   localparam int unsigned WINDOW_BYTES = WINDOW_PAGES * PAGE_BYTES;
   localparam int unsigned SLOT_COUNT   = WINDOW_BYTES / GRANULE_BYTES;
   localparam int unsigned IDX_W        = $clog2(SLOT_COUNT);
   localparam int unsigned ENT_W        = IDX_W + 2;
   localparam int unsigned CLS_W        = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int unsigned O_W          = PS + 1;
   localparam int unsigned SUM_W        = ((O_W > STRIDE_W) ? O_W : STRIDE_W) + 1;
   localparam int unsigned WIN_W        = $clog2(WINDOW_BYTES);

   localparam logic [ADDR_W-1:0]   WIN_BYTES_A = ADDR_W'(WINDOW_BYTES);
   localparam logic [ADDR_W-1:0]   LAST_PAGE   = ADDR_W'(WINDOW_BYTES - PAGE_BYTES);
   localparam logic [ADDR_W-1:0]   PAGE_M1     = ADDR_W'(PAGE_BYTES - 1);
   localparam logic [ADDR_W:0]     PAGE_X      = (ADDR_W + 1)'(PAGE_BYTES);
   localparam logic [SUM_W-1:0]    PAGE_S      = SUM_W'(PAGE_BYTES);
   localparam logic [STRIDE_W-1:0] GRAN_M1     = STRIDE_W'(GRANULE_BYTES - 1);
   localparam logic [CLS_W-1:0]    CLS_LAST    = CLS_W'(CLASS_COUNT - 1);
   localparam logic [IDX_W-1:0]    SLOT_LAST   = IDX_W'(SLOT_COUNT - 1);
   localparam logic [COUNT_W-1:0]  COUNT_MAX   = '1;

   typedef enum logic [11:0] {
      ST_CLEAR    = 12'b0000_0000_0001,
      ST_IDLE     = 12'b0000_0000_0010,
      ST_DONATE   = 12'b0000_0000_0100,
      ST_CARVE    = 12'b0000_0000_1000,
      ST_ALLOC    = 12'b0000_0001_0000,
      ST_ALLOC_RD = 12'b0000_0010_0000,
      ST_FREE_CHK = 12'b0000_0100_0000,
      ST_FREE_REM = 12'b0000_1000_0000,
      ST_FREE_IDX = 12'b0001_0000_0000,
      ST_FREE_RD  = 12'b0010_0000_0000,
      ST_QUERY    = 12'b0100_0000_0000,
      ST_FIN      = 12'b1000_0000_0000
   } state_type;

   function automatic logic [STRIDE_W-1:0] stride_of(input logic [SIZE_W-1:0] s);
      logic [STRIDE_W-1:0] t;
      t = {1'b0, s} + GRAN_M1;
      return t & ~GRAN_M1;
   endfunction

   state_type          state_ff, state_in;
   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [CLS_W-1:0]   cls_ff, cls_in;
   logic [WIN_W-1:0]   off_ff, off_in;
   logic [O_W-1:0]     o_ff, o_in;
   logic [STRIDE_W-1:0] stride_ff, stride_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [CLS_W-1:0]   turn_ff, turn_in;
   rsp_type            res_ff, res_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]  base_ff, base_in;

   logic [SIZE_W-1:0]  csize_ff [CLASS_COUNT];
   logic [SIZE_W-1:0]  csize_in [CLASS_COUNT];
   logic [IDX_W-1:0]   head_ff  [CLASS_COUNT];
   logic [IDX_W-1:0]   head_in  [CLASS_COUNT];
   logic               hvalid_ff [CLASS_COUNT];
   logic               hvalid_in [CLASS_COUNT];
   logic [COUNT_W-1:0] fcnt_ff  [CLASS_COUNT];
   logic [COUNT_W-1:0] fcnt_in  [CLASS_COUNT];
   logic [COUNT_W-1:0] ucnt_ff  [CLASS_COUNT];
   logic [COUNT_W-1:0] ucnt_in  [CLASS_COUNT];
   logic [ADDR_W-1:0]  low_ff   [CLASS_COUNT];
   logic [ADDR_W-1:0]  low_in   [CLASS_COUNT];
   logic [ADDR_W-1:0]  high_ff  [CLASS_COUNT];
   logic [ADDR_W-1:0]  high_in  [CLASS_COUNT];

   logic [ENT_W-1:0]   slot_mem [SLOT_COUNT];
   logic [ENT_W-1:0]   mem_q_ff;
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENT_W-1:0]   mem_wdata;
   logic [IDX_W-1:0]   mem_raddr;

   logic               rem_start;
   logic               rem_done;
   logic               rem_zero;
   logic [ADDR_W-1:0]  rem_dividend;
   logic [STRIDE_W-1:0] rem_divisor;

   logic               match_hit;
   logic [CLS_W-1:0]   match_cls;

   sfla_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (rem_dividend),
      .divisor  (rem_divisor),
      .done     (rem_done),
      .zero     (rem_zero)
   );

   always_comb begin
      match_hit = 1'b0;
      match_cls = '0;
      for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
         if (csize_ff[c] == size_ff) begin
            match_hit = 1'b1;
            match_cls = CLS_W'(c);
         end
      end
   end

   assign rem_dividend = addr_ff - low_ff[cls_ff];
   assign rem_divisor  = stride_of(csize_ff[cls_ff]);

   always_comb begin
      logic [ADDR_W-1:0]  off;
      logic [ADDR_W:0]    top;
      logic [ADDR_W-1:0]  hi_new;
      logic [SUM_W-1:0]   sum;
      logic [WIN_W:0]     slot_off;
      logic [STRIDE_W-1:0] st;
      logic               push_en;
      logic [IDX_W-1:0]   push_idx;

      state_in     = state_ff;
      kind_in      = kind_ff;
      size_in      = size_ff;
      addr_in      = addr_ff;
      cls_in       = cls_ff;
      off_in       = off_ff;
      o_in         = o_ff;
      stride_in    = stride_ff;
      idx_in       = idx_ff;
      clr_in       = clr_ff;
      turn_in      = turn_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      base_in      = base_ff;
      csize_in     = csize_ff;
      head_in      = head_ff;
      hvalid_in    = hvalid_ff;
      fcnt_in      = fcnt_ff;
      ucnt_in      = ucnt_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_wdata    = '0;
      mem_raddr    = idx_ff;
      rem_start    = 1'b0;
      push_en      = 1'b0;
      push_idx     = idx_ff;
      off          = addr_ff - base_ff;
      top          = {1'b0, addr_ff} + PAGE_X;
      hi_new       = addr_ff + PAGE_M1;
      sum          = SUM_W'(o_ff) + SUM_W'(stride_ff);
      slot_off     = (WIN_W + 1)'(off_ff) + (WIN_W + 1)'(o_ff);
      st           = stride_of(csize_ff[cls_ff]);

      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SMALL_BYTES, CSR_MEDIUM_BYTES, CSR_LARGE_BYTES: begin
               if (32'(csr_index) < CLASS_COUNT) begin
                  csize_in[CLS_W'(csr_index)] = csr_data[SIZE_W-1:0];
               end
            end
            CSR_WINDOW_BASE: base_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + IDX_W'(1);
            if (clr_ff == SLOT_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_payload.kind;
               size_in = req_payload.size;
               addr_in = req_payload.address;
               cls_in  = '0;
               res_in  = '0;
               unique case (kind_type'(req_payload.kind))
                  KIND_DONATE: state_in = ST_DONATE;
                  KIND_ALLOC:  state_in = ST_ALLOC;
                  KIND_FREE:   state_in = ST_FREE_CHK;
                  KIND_QUERY:  state_in = ST_QUERY;
                  default:     state_in = ST_QUERY;
               endcase
            end
         end
         ST_DONATE: begin
            turn_in  = (turn_ff == CLS_LAST) ? '0 : turn_ff + CLS_W'(1);
            cls_in   = turn_ff;
            state_in = ST_FIN;
            if (addr_ff != '0 && off[PS-1:0] == '0 && off <= LAST_PAGE &&
                !(top[ADDR_W] && top[ADDR_W-1:0] != '0)) begin
               res_in.success = 1'b1;
               if (low_ff[turn_ff] == '0 || addr_ff < low_ff[turn_ff]) begin
                  low_in[turn_ff] = addr_ff;
               end
               if (hi_new > high_ff[turn_ff]) begin
                  high_in[turn_ff] = hi_new;
               end
               stride_in = stride_of(csize_ff[turn_ff]);
               off_in    = off[WIN_W-1:0];
               o_in      = '0;
               if (stride_of(csize_ff[turn_ff]) != '0) begin
                  state_in = ST_CARVE;
               end
            end
         end
         ST_CARVE: begin
            if (sum <= PAGE_S) begin
               push_en  = 1'b1;
               push_idx = slot_off[GS +: IDX_W];
               o_in     = sum[O_W-1:0];
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_ALLOC: begin
            if (match_hit && hvalid_ff[match_cls]) begin
               cls_in    = match_cls;
               idx_in    = head_ff[match_cls];
               mem_raddr = head_ff[match_cls];
               state_in  = ST_ALLOC_RD;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_ALLOC_RD: begin
            head_in[cls_ff]   = mem_q_ff[IDX_W-1:0];
            hvalid_in[cls_ff] = mem_q_ff[IDX_W];
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = {1'b0, mem_q_ff[IDX_W:0]};
            if (fcnt_ff[cls_ff] != '0) begin
               fcnt_in[cls_ff] = fcnt_ff[cls_ff] - COUNT_W'(1);
            end
            if (ucnt_ff[cls_ff] != COUNT_MAX) begin
               ucnt_in[cls_ff] = ucnt_ff[cls_ff] + COUNT_W'(1);
            end
            res_in.granted_address = base_ff + (ADDR_W'(idx_ff) << GS);
            res_in.success         = 1'b1;
            state_in = ST_FIN;
         end
         ST_FREE_CHK: begin
            if (addr_ff == '0) begin
               state_in = ST_FIN;
            end else if (addr_ff >= low_ff[cls_ff] && addr_ff <= high_ff[cls_ff] &&
                         st != '0) begin
               rem_start = 1'b1;
               state_in  = ST_FREE_REM;
            end else if (cls_ff == CLS_LAST) begin
               state_in = ST_FIN;
            end else begin
               cls_in = cls_ff + CLS_W'(1);
            end
         end
         ST_FREE_REM: begin
            if (rem_done) begin
               if (rem_zero) begin
                  state_in = ST_FREE_IDX;
               end else if (cls_ff == CLS_LAST) begin
                  state_in = ST_FIN;
               end else begin
                  cls_in   = cls_ff + CLS_W'(1);
                  state_in = ST_FREE_CHK;
               end
            end
         end
         ST_FREE_IDX: begin
            if (off >= WIN_BYTES_A) begin
               state_in = ST_FIN;
            end else begin
               idx_in    = off[GS +: IDX_W];
               mem_raddr = off[GS +: IDX_W];
               state_in  = ST_FREE_RD;
            end
         end
         ST_FREE_RD: begin
            if (!mem_q_ff[IDX_W+1]) begin
               push_en  = 1'b1;
               push_idx = idx_ff;
               if (ucnt_ff[cls_ff] != '0) begin
                  ucnt_in[cls_ff] = ucnt_ff[cls_ff] - COUNT_W'(1);
               end
               res_in.success = 1'b1;
            end
            state_in = ST_FIN;
         end
         ST_QUERY: begin
            if (match_hit) begin
               res_in.free_objects = fcnt_ff[match_cls];
               res_in.live_objects = ucnt_ff[match_cls];
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (push_en) begin
         mem_we    = 1'b1;
         mem_waddr = push_idx;
         mem_wdata = {1'b1, hvalid_ff[cls_ff], head_ff[cls_ff]};
         head_in[cls_ff]   = push_idx;
         hvalid_in[cls_ff] = 1'b1;
         if (fcnt_ff[cls_ff] != COUNT_MAX) begin
            fcnt_in[cls_ff] = fcnt_ff[cls_ff] + COUNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= slot_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         turn_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
         for (int c = 0; c < CLASS_COUNT; c++) begin
            csize_ff[c]  <= reset_size(c);
            head_ff[c]   <= '0;
            hvalid_ff[c] <= 1'b0;
            fcnt_ff[c]   <= '0;
            ucnt_ff[c]   <= '0;
            low_ff[c]    <= '0;
            high_ff[c]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         turn_ff      <= turn_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
         csize_ff     <= csize_in;
         head_ff      <= head_in;
         hvalid_ff    <= hvalid_in;
         fcnt_ff      <= fcnt_in;
         ucnt_ff      <= ucnt_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
      end
      kind_ff   <= kind_in;
      size_ff   <= size_in;
      addr_ff   <= addr_in;
      cls_ff    <= cls_in;
      off_ff    <= off_in;
      o_ff      <= o_in;
      stride_ff <= stride_in;
      idx_ff    <= idx_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

endmodule

`default_nettype wire

>>> tb/sv/slab_free_list_allocator_checker.sv
// Checker of the slab allocator: predicts every response and compares it.
`timescale 1ns / 1ps

module slab_free_list_allocator_checker
   import sfla_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_data,
   output int                   fail_count,
   output int                   pending
);

   localparam int unsigned PAGE    = DEF_PAGE_BYTES;
   localparam int unsigned GRAN    = DEF_GRANULE_BYTES;
   localparam int unsigned CLASSES = DEF_CLASS_COUNT;
   localparam int unsigned WIN_B   = DEF_WINDOW_PAGES * DEF_PAGE_BYTES;
   localparam int unsigned SLOTS   = WIN_B / GRAN;
   localparam int unsigned CNT_MAX = 8191;

   logic [12:0]       slot_next [SLOTS];
   bit                slot_next_ok [SLOTS];
   bit                slot_free [SLOTS];
   logic [12:0]       head [CLASSES];
   bit                head_ok [CLASSES];
   int unsigned       free_cnt [CLASSES];
   int unsigned       used_cnt [CLASSES];
   logic [ADDR_W-1:0] low_bound [CLASSES];
   logic [ADDR_W-1:0] high_bound [CLASSES];
   logic [SIZE_W-1:0] obj_bytes [CLASSES];
   logic [ADDR_W-1:0] win_base;
   int unsigned       turn;
   rsp_type           expected_rsp_q [$];
   int                fails;

   function automatic int unsigned stride_of(int unsigned c);
      return ((int'(obj_bytes[c]) + GRAN - 1) / GRAN) * GRAN;
   endfunction

   function automatic void push_slot(int unsigned c, int unsigned idx);
      slot_next[idx]    = head[c];
      slot_next_ok[idx] = head_ok[c];
      slot_free[idx]    = 1;
      head[c]           = idx[12:0];
      head_ok[c]        = 1;
      if (free_cnt[c] < CNT_MAX) free_cnt[c]++;
   endfunction

   function automatic bit donate_page(logic [ADDR_W-1:0] addr);
      int unsigned       c, st, o;
      logic [ADDR_W-1:0] off;
      c = (turn >= CLASSES) ? 0 : turn;
      turn = (c + 1) % CLASSES;
      if (addr == 0) return 0;
      off = addr - win_base;
      if (off % PAGE != 0) return 0;
      if (off > WIN_B - PAGE) return 0;
      if ({1'b0, addr} + 33'(PAGE) > 33'h1_0000_0000) return 0;
      if (low_bound[c] == 0 || addr < low_bound[c]) low_bound[c] = addr;
      if (addr + (PAGE - 1) > high_bound[c]) high_bound[c] = addr + (PAGE - 1);
      st = stride_of(c);
      if (st != 0)
         for (o = 0; o + st <= PAGE; o += st)
            if ((off + o) / GRAN < SLOTS) push_slot(c, (off + o) / GRAN);
      return 1;
   endfunction

   function automatic bit free_object(logic [ADDR_W-1:0] addr);
      int unsigned       c, st, idx;
      logic [ADDR_W-1:0] off;
      if (addr == 0) return 0;
      for (c = 0; c < CLASSES; c++) begin
         st = stride_of(c);
         if (addr < low_bound[c] || addr > high_bound[c]) continue;
         if (st == 0) continue;
         if ((addr - low_bound[c]) % st != 0) continue;
         off = addr - win_base;
         if (off >= WIN_B) return 0;
         idx = off / GRAN;
         if (slot_free[idx]) return 0;
         push_slot(c, idx);
         if (used_cnt[c] > 0) used_cnt[c]--;
         return 1;
      end
      return 0;
   endfunction

   function automatic bit alloc_object(logic [SIZE_W-1:0] size, output logic [ADDR_W-1:0] got);
      int unsigned c, idx;
      got = 0;
      for (c = 0; c < CLASSES; c++) begin
         if (obj_bytes[c] != size) continue;
         if (!head_ok[c]) return 0;
         idx = head[c];
         head[c]        = slot_next[idx];
         head_ok[c]     = slot_next_ok[idx];
         slot_free[idx] = 0;
         if (free_cnt[c] > 0) free_cnt[c]--;
         if (used_cnt[c] < CNT_MAX) used_cnt[c]++;
         got = win_base + idx * GRAN;
         return 1;
      end
      return 0;
   endfunction

   function automatic rsp_type predict_slab(req_type r);
      rsp_type     p;
      int unsigned c;
      p = '0;
      case (kind_type'(r.kind))
         KIND_DONATE: p.success = donate_page(r.address);
         KIND_ALLOC:  p.success = alloc_object(r.size, p.granted_address);
         KIND_FREE:   p.success = free_object(r.address);
         default: begin
            for (c = 0; c < CLASSES; c++)
               if (obj_bytes[c] == r.size) begin
                  p.free_objects = free_cnt[c][COUNT_W-1:0];
                  p.live_objects = used_cnt[c][COUNT_W-1:0];
                  break;
               end
         end
      endcase
      return p;
   endfunction

   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_next[i] = 0; slot_next_ok[i] = 0; slot_free[i] = 0;
         end
         for (int c = 0; c < CLASSES; c++) begin
            head[c] = 0; head_ok[c] = 0; free_cnt[c] = 0; used_cnt[c] = 0;
            low_bound[c] = 0; high_bound[c] = 0; obj_bytes[c] = reset_size(c);
         end
         win_base = 0;
         turn = 0;
         expected_rsp_q.delete();
         fails = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_SMALL_BYTES:  obj_bytes[0] = csr_data[SIZE_W-1:0];
               CSR_MEDIUM_BYTES: obj_bytes[1] = csr_data[SIZE_W-1:0];
               CSR_LARGE_BYTES:  obj_bytes[2] = csr_data[SIZE_W-1:0];
               default:          win_base     = csr_data;
            endcase
         end
         if (req_valid && req_ready) expected_rsp_q.push_back(predict_slab(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               fails++;
               if (fails <= 10) $display("unexpected response %h", rsp_payload);
            end else begin
               e = expected_rsp_q.pop_front();
               if (e.granted_address !== rsp_payload.granted_address ||
                   e.success !== rsp_payload.success ||
                   e.free_objects !== rsp_payload.free_objects ||
                   e.live_objects !== rsp_payload.live_objects) begin
                  fails++;
                  if (fails <= 10)
                     $display({"mismatch: expected addr %h ok %b free %0d live %0d,",
                               " got addr %h ok %b free %0d live %0d"},
                              e.granted_address, e.success, e.free_objects,
                              e.live_objects, rsp_payload.granted_address,
                              rsp_payload.success, rsp_payload.free_objects,
                              rsp_payload.live_objects);
               end
            end
         end
      end
      fail_count <= fails;
      pending    <= expected_rsp_q.size();
   end

endmodule

>>> tb/sv/slab_free_list_allocator_top_test.sv
// Testbench top of the slab allocator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module slab_free_list_allocator_top_test;
   import sfla_pkg::*;

   logic                 clock = 0;
   logic                 reset = 1;
   logic                 req_valid = 0;
   logic                 req_ready;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 0;
   rsp_type              rsp_payload;
   logic                 csr_valid = 0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_data = '0;
   int                   fail_count;
   int                   pending;

   int                tx_idle_pct = 0;
   int                rx_stall_pct = 0;
   int                hold_asked = 0;
   int                hold_served = 0;
   int                hold_left = 0;
   logic [SIZE_W-1:0] sizes [3];
   logic [ADDR_W-1:0] base;
   logic [ADDR_W-1:0] granted_q [$];

   always #2 clock = ~clock;

   slab_free_list_allocator_top dut (
      .clock, .reset, .req_valid, .req_ready, .req_payload, .rsp_valid, .rsp_ready,
      .rsp_payload, .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   slab_free_list_allocator_checker checker_i (
      .clock, .reset, .req_valid, .req_ready, .req_payload, .rsp_valid, .rsp_ready,
      .rsp_payload, .csr_valid, .csr_ready, .csr_index, .csr_data, .fail_count, .pending
   );

   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_served = hold_asked;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
      if (!reset && rsp_valid && rsp_ready && rsp_payload.success &&
          rsp_payload.granted_address != 0)
         granted_q.push_back(rsp_payload.granted_address);
   end

   initial begin
      #20ms;
      $display("FAILURE");
      $finish;
   end

   task automatic send_request(kind_type k, logic [SIZE_W-1:0] s, logic [ADDR_W-1:0] a);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid           <= 1;
      req_payload.kind    <= k;
      req_payload.size    <= s;
      req_payload.address <= a;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [ADDR_W-1:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic set_pool(logic [SIZE_W-1:0] s0, logic [SIZE_W-1:0] s1,
                           logic [SIZE_W-1:0] s2, logic [ADDR_W-1:0] b);
      write_csr(CSR_SMALL_BYTES, s0);
      write_csr(CSR_MEDIUM_BYTES, s1);
      write_csr(CSR_LARGE_BYTES, s2);
      write_csr(CSR_WINDOW_BASE, b);
      sizes[0] = s0; sizes[1] = s1; sizes[2] = s2; base = b;
      granted_q.delete();
   endtask

   task automatic random_request();
      int                r, i;
      logic [ADDR_W-1:0] a;
      logic [SIZE_W-1:0] s;
      r = $urandom_range(0, 99);
      s = ($urandom_range(0, 99) < 85) ? sizes[$urandom_range(0, 2)] : SIZE_W'($urandom);
      if (r < 12) begin
         a = base + $urandom_range(0, 7) * 4096;
         case ($urandom_range(0, 9))
            0: a = 0;
            1: a = $urandom;
            2: a = a + 8 * $urandom_range(1, 511);
            3: a = base + $urandom_range(8, 12) * 4096;
            default: ;
         endcase
         send_request(KIND_DONATE, SIZE_W'($urandom), a);
      end else if (r < 45) begin
         send_request(KIND_ALLOC, s, $urandom);
      end else if (r < 80) begin
         if (granted_q.size() != 0 && $urandom_range(0, 99) < 70) begin
            i = $urandom_range(0, granted_q.size() - 1);
            a = granted_q[i];
            if ($urandom_range(0, 99) >= 20) granted_q.delete(i);
         end else if ($urandom_range(0, 1)) begin
            a = base + 8 * $urandom_range(0, 4095);
         end else begin
            a = $urandom;
         end
         send_request(KIND_FREE, SIZE_W'($urandom), a);
      end else begin
         send_request(KIND_QUERY, s, $urandom);
      end
   endtask

   initial begin
      logic [ADDR_W-1:0] a;
      sizes[0] = 32; sizes[1] = 128; sizes[2] = 512; base = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // defaults, page at the window start is a null address
      send_request(KIND_DONATE, 0, 0);
      send_request(KIND_DONATE, 0, 32'h1000);
      send_request(KIND_DONATE, 0, 32'h2000);
      send_request(KIND_DONATE, 0, 32'h3008);
      send_request(KIND_DONATE, 0, 32'h8000);
      send_request(KIND_DONATE, 0, 32'h7000);
      send_request(KIND_ALLOC, 32, 0);
      send_request(KIND_ALLOC, 128, 0);
      send_request(KIND_ALLOC, 512, 0);
      send_request(KIND_ALLOC, 512, 0);
      send_request(KIND_ALLOC, 100, 0);
      send_request(KIND_QUERY, 32, 0);
      send_request(KIND_QUERY, 13'h1FFF, 32'hFFFF_FFFF);
      drain();
      a = granted_q.size() ? granted_q[0] : 32'h1FE0;
      send_request(KIND_FREE, 0, a);
      send_request(KIND_FREE, 0, a);
      send_request(KIND_FREE, 0, a + 8);
      send_request(KIND_FREE, 0, 0);
      send_request(KIND_FREE, 13'h1FFF, 32'hFFFF_FFFF);
      send_request(KIND_QUERY, 128, 0);
      send_request(KIND_QUERY, 512, 0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_pool(32, 128, 512, 0);
            1: set_pool(8, 4096, 24, 32'h0001_0000);
            2: set_pool(4096, 8, 1000, 32'hFFFF_8000);
            3: set_pool(16, 64, 256, 32'h0020_0000);
            4: set_pool(40, 40, 4088, 32'h8000_0000);
            5: set_pool(48, 200, 8, 32'hFFFF_A000);
            6: set_pool(64, 512, 2048, 32'h0001_0000);
            default: set_pool(8, 8, 4096, 32'hFFFF_F000);
         endcase
         case (ph % 4)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 73; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 73; end
            default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
         endcase
         for (int n = 0; n < 165; n++) begin
            if (ph == 4 && n == 40) hold_asked++;
            random_request();
         end
         drain();
      end

      if (fail_count == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
